FILE: rtl/marching_squares_cell_segments_defines.svh
// Assertion macros shared by the marching squares checker
`ifndef MARCHING_SQUARES_CELL_SEGMENTS_DEFINES_SVH
`define MARCHING_SQUARES_CELL_SEGMENTS_DEFINES_SVH

// Next-cycle implication that also holds while reset is high
`define MSC_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high
`define MSC_ASSERT_NEXT_RST(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/msc_pkg.sv
// Types, constants and segment table for the marching squares cell block
package msc_pkg;

   localparam int unsigned QuoWidth   = 17;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
   localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

   typedef logic signed [31:0] q16_type;

   localparam q16_type NoDataLevel = {1'b1, 31'b0};

   typedef enum logic [1:0] {
      EDGE_TOP    = 2'd0,
      EDGE_RIGHT  = 2'd1,
      EDGE_BOTTOM = 2'd2,
      EDGE_LEFT   = 2'd3
   } edge_code_type;

   typedef struct packed {
      q16_type [3:0] lev;
      q16_type [3:0] px;
      q16_type [3:0] py;
   } cell_type;

   typedef struct packed {
      q16_type lev_a;
      q16_type lev_b;
      q16_type pa_x;
      q16_type pa_y;
      q16_type pb_x;
      q16_type pb_y;
   } edge_type;

   typedef struct packed {
      logic     last;
      edge_type from_edge;
      edge_type to_edge;
   } seg_type;

   typedef struct packed {
      edge_code_type start_edge;
      edge_code_type end_edge;
      logic          last;
   } seg_plan_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [31:0]        den;
      logic [32:0]        rem;
      logic [QuoWidth-1:0] quo;
      q16_type            pa_x;
      q16_type            pa_y;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
   } div_lane_type;

   function automatic seg_plan_type plan_segment(logic [3:0] mask, logic low_center,
                                                 logic second);
      seg_plan_type p;
      logic         flip;
      flip = (low_center == (mask == 4'd5));
      unique case (mask) inside
         4'd1, 4'd14: p = '{EDGE_LEFT, EDGE_TOP, 1'b1};
         4'd2, 4'd13: p = '{EDGE_TOP, EDGE_RIGHT, 1'b1};
         4'd3, 4'd12: p = '{EDGE_LEFT, EDGE_RIGHT, 1'b1};
         4'd4, 4'd11: p = '{EDGE_RIGHT, EDGE_BOTTOM, 1'b1};
         4'd6, 4'd9:  p = '{EDGE_TOP, EDGE_BOTTOM, 1'b1};
         4'd7, 4'd8:  p = '{EDGE_LEFT, EDGE_BOTTOM, 1'b1};
         4'd5, 4'd10: begin
            if (flip) begin
               if (second) p = '{EDGE_BOTTOM, EDGE_LEFT, 1'b1};
               else        p = '{EDGE_TOP, EDGE_RIGHT, 1'b0};
            end else begin
               if (second) p = '{EDGE_RIGHT, EDGE_BOTTOM, 1'b1};
               else        p = '{EDGE_LEFT, EDGE_TOP, 1'b0};
            end
         end
         default: p = '{EDGE_LEFT, EDGE_TOP, 1'b1};
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/msc_front.sv
// Front end: holds one cell, classifies it and issues its segments
module msc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  msc_pkg::cell_type         req_cell,
   input  msc_pkg::q16_type          threshold,
   input  msc_pkg::queue_status_type qstat,
   output logic                      push,
   output msc_pkg::seg_type          push_data
);
   import msc_pkg::*;

   cell_type     cell_ff, cell_in;
   logic         cell_vld_ff, cell_vld_in;
   logic         second_ff, second_in;
   logic [3:0]   mask;
   logic         no_data, skip, low_center, done, accept;
   logic [33:0]  lev_sum, thr4;
   seg_plan_type plan;

   function automatic edge_type make_edge(cell_type c, edge_code_type e);
      edge_type r;
      unique case (e)
         EDGE_TOP:    r = '{c.lev[0], c.lev[1], c.px[0], c.py[0], c.px[1], c.py[1]};
         EDGE_RIGHT:  r = '{c.lev[1], c.lev[2], c.px[1], c.py[1], c.px[2], c.py[2]};
         EDGE_BOTTOM: r = '{c.lev[2], c.lev[3], c.px[2], c.py[2], c.px[3], c.py[3]};
         EDGE_LEFT:   r = '{c.lev[3], c.lev[0], c.px[3], c.py[3], c.px[0], c.py[0]};
         default:     r = '{c.lev[0], c.lev[1], c.px[0], c.py[0], c.px[1], c.py[1]};
      endcase
      return r;
   endfunction

   always_comb begin
      no_data = 1'b0;
      for (int i = 0; i < 4; i++) begin
         mask[i] = ($signed(cell_ff.lev[i]) <= $signed(threshold));
         if (cell_ff.lev[i] == NoDataLevel) begin
            no_data = 1'b1;
         end
      end
      lev_sum = {{2{cell_ff.lev[0][31]}}, cell_ff.lev[0]}
              + {{2{cell_ff.lev[1][31]}}, cell_ff.lev[1]}
              + {{2{cell_ff.lev[2][31]}}, cell_ff.lev[2]}
              + {{2{cell_ff.lev[3][31]}}, cell_ff.lev[3]};
      thr4       = {threshold, 2'b00};
      low_center = ($signed(lev_sum) <= $signed(thr4));
      skip       = no_data || (mask == 4'd0) || (mask == 4'd15);
      plan       = plan_segment(mask, low_center, second_ff);
   end

   always_comb begin
      push        = cell_vld_ff && !skip && !qstat.full;
      done        = cell_vld_ff && (skip || (push && plan.last));
      busy        = cell_vld_ff && !done;
      accept      = start && !busy;
      push_data   = '{plan.last, make_edge(cell_ff, plan.start_edge),
                      make_edge(cell_ff, plan.end_edge)};
      cell_in     = accept ? req_cell : cell_ff;
      cell_vld_in = accept || (cell_vld_ff && !done);
      second_in   = accept ? 1'b0 : (push ? 1'b1 : second_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= 1'b0;
         second_ff   <= 1'b0;
      end else begin
         cell_vld_ff <= cell_vld_in;
         second_ff   <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

endmodule

FILE: rtl/msc_queue.sv
// Short segment queue between front and back end
module msc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  msc_pkg::seg_type          push_data,
   input  logic                      pop,
   output msc_pkg::seg_type          pop_data,
   output msc_pkg::queue_status_type qstat
);
   import msc_pkg::*;

   seg_type              entry_ff [QueueDepth];
   logic [QPtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0] count_ff, count_in;
   logic                 do_pop;

   always_comb begin
      qstat.empty = (count_ff == '0);
      qstat.full  = (count_ff == QCntWidth'(QueueDepth));
      do_pop      = pop && !qstat.empty;
      pop_data    = entry_ff[rd_ptr_ff];
      wr_ptr_in   = push ? QPtrWidth'((32'(wr_ptr_ff) + 1) % QueueDepth) : wr_ptr_ff;
      rd_ptr_in   = do_pop ? QPtrWidth'((32'(rd_ptr_ff) + 1) % QueueDepth) : rd_ptr_ff;
      count_in    = count_ff + QCntWidth'(push) - QCntWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/msc_back.sv
// Back end: divider pipeline, scaling and segment output
module msc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  msc_pkg::q16_type          threshold,
   input  msc_pkg::queue_status_type qstat,
   input  msc_pkg::seg_type          pop_data,
   output logic                      pop,
   output logic                      rsp_valid,
   output msc_pkg::q16_type          rsp_start_x,
   output msc_pkg::q16_type          rsp_start_y,
   output msc_pkg::q16_type          rsp_end_x,
   output msc_pkg::q16_type          rsp_end_y,
   output logic                      rsp_last_in_cell
);
   import msc_pkg::*;

   logic               prep_vld_ff;
   logic               prep_last_ff;
   div_lane_type       prep_lane_ff [2];
   logic               div_vld_ff  [QuoWidth];
   logic               div_last_ff [QuoWidth];
   div_lane_type       div_lane_ff [QuoWidth][2];
   logic               mul_vld_ff, mul_last_ff;
   q16_type            mul_pa_x_ff [2];
   q16_type            mul_pa_y_ff [2];
   logic signed [50:0] mul_px_ff [2];
   logic signed [50:0] mul_py_ff [2];
   logic               out_vld_ff, out_last_ff;
   q16_type            out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;

   function automatic div_lane_type prep_lane(edge_type e, q16_type t);
      div_lane_type       r;
      logic signed [32:0] num, den;
      num    = {t[31], t} - {e.lev_a[31], e.lev_a};
      den    = {e.lev_b[31], e.lev_b} - {e.lev_a[31], e.lev_a};
      r.rem  = {1'b0, num[32] ? 32'(-num) : num[31:0]};
      r.den  = den[32] ? 32'(-den) : den[31:0];
      r.quo  = '0;
      r.pa_x = e.pa_x;
      r.pa_y = e.pa_y;
      r.dx   = {e.pb_x[31], e.pb_x} - {e.pa_x[31], e.pa_x};
      r.dy   = {e.pb_y[31], e.pb_y} - {e.pa_y[31], e.pa_y};
      return r;
   endfunction

   // one restoring step: first step compares the bare numerator
   function automatic div_lane_type div_step(div_lane_type l, logic first);
      div_lane_type r;
      logic [32:0]  trial;
      logic         take;
      trial = first ? l.rem : {l.rem[31:0], 1'b0};
      take  = (trial >= {1'b0, l.den});
      r     = l;
      r.rem = take ? trial - {1'b0, l.den} : trial;
      r.quo = {l.quo[QuoWidth-2:0], take};
      return r;
   endfunction

   assign pop = !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else begin
         prep_vld_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      prep_last_ff    <= pop_data.last;
      prep_lane_ff[0] <= prep_lane(pop_data.from_edge, threshold);
      prep_lane_ff[1] <= prep_lane(pop_data.to_edge, threshold);
   end

   for (genvar j = 0; j < QuoWidth; j++) begin : g_div
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               div_vld_ff[j] <= 1'b0;
            end else begin
               div_vld_ff[j] <= prep_vld_ff;
            end
         end
         always_ff @(posedge clock) begin
            div_last_ff[j]    <= prep_last_ff;
            div_lane_ff[j][0] <= div_step(prep_lane_ff[0], 1'b1);
            div_lane_ff[j][1] <= div_step(prep_lane_ff[1], 1'b1);
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               div_vld_ff[j] <= 1'b0;
            end else begin
               div_vld_ff[j] <= div_vld_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            div_last_ff[j]    <= div_last_ff[j-1];
            div_lane_ff[j][0] <= div_step(div_lane_ff[j-1][0], 1'b0);
            div_lane_ff[j][1] <= div_step(div_lane_ff[j-1][1], 1'b0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= div_vld_ff[QuoWidth-1];
         out_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_last_ff <= div_last_ff[QuoWidth-1];
      for (int k = 0; k < 2; k++) begin
         mul_pa_x_ff[k] <= div_lane_ff[QuoWidth-1][k].pa_x;
         mul_pa_y_ff[k] <= div_lane_ff[QuoWidth-1][k].pa_y;
         mul_px_ff[k]   <= $signed({1'b0, div_lane_ff[QuoWidth-1][k].quo})
                         * div_lane_ff[QuoWidth-1][k].dx;
         mul_py_ff[k]   <= $signed({1'b0, div_lane_ff[QuoWidth-1][k].quo})
                         * div_lane_ff[QuoWidth-1][k].dy;
      end
      out_last_ff <= mul_last_ff;
      // bits 47:16 are the floored offset, modulo the 32-bit result
      out_sx_ff   <= mul_pa_x_ff[0] + mul_px_ff[0][47:16];
      out_sy_ff   <= mul_pa_y_ff[0] + mul_py_ff[0][47:16];
      out_ex_ff   <= mul_pa_x_ff[1] + mul_px_ff[1][47:16];
      out_ey_ff   <= mul_pa_y_ff[1] + mul_py_ff[1][47:16];
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_last_in_cell = out_last_ff;
   assign rsp_start_x      = out_sx_ff;
   assign rsp_start_y      = out_sy_ff;
   assign rsp_end_x        = out_ex_ff;
   assign rsp_end_y        = out_ey_ff;

endmodule

FILE: rtl/marching_squares_cell_segments.sv
// Top level of the marching squares cell segment extractor
//
// Input: one grid cell per transaction (four corner levels and positions,
// top-left, top-right, bottom-right, bottom-left, all signed Q16.16). A
// transaction is taken at a rising edge with start high and busy low.
// Output: each isoline segment appears for one cycle with rsp_valid high;
// rsp_last_in_cell marks the final segment of a cell. The receiver cannot
// hold results off, and the pipeline never waits on it.
// Configuration: csr_wr_en writes csr_wr_data into the contour threshold;
// write it only while no cell is in flight.
// A taken cell's first segment passes the cell register, queue and each
// back end stage; a saddle cell's second segment follows in the next
// cycle. Throughput: one cell per cycle, but a saddle cell is busy while
// its first segment issues. The front end issues one segment a cycle into
// the queue; the back end divides with a 17-stage restoring pipeline, one
// quotient bit per stage for both edge points, and takes new segments while
// older ones are in it. Reset clears the threshold to zero and empties the
// front end, queue and pipeline; busy is low in the cycle after reset.
module marching_squares_cell_segments (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  msc_pkg::q16_type req_level_0,
   input  msc_pkg::q16_type req_level_1,
   input  msc_pkg::q16_type req_level_2,
   input  msc_pkg::q16_type req_level_3,
   input  msc_pkg::q16_type req_pos_x_0,
   input  msc_pkg::q16_type req_pos_y_0,
   input  msc_pkg::q16_type req_pos_x_1,
   input  msc_pkg::q16_type req_pos_y_1,
   input  msc_pkg::q16_type req_pos_x_2,
   input  msc_pkg::q16_type req_pos_y_2,
   input  msc_pkg::q16_type req_pos_x_3,
   input  msc_pkg::q16_type req_pos_y_3,
   output logic             rsp_valid,
   output msc_pkg::q16_type rsp_start_x,
   output msc_pkg::q16_type rsp_start_y,
   output msc_pkg::q16_type rsp_end_x,
   output msc_pkg::q16_type rsp_end_y,
   output logic             rsp_last_in_cell,
   input  logic             csr_wr_en,
   input  msc_pkg::q16_type csr_wr_data
);
   import msc_pkg::*;

   q16_type          threshold_ff, threshold_in;
   cell_type         req_cell;
   queue_status_type qstat;
   seg_type          push_data, pop_data;
   logic             push, pop;

   // hold the threshold between writes
   assign threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // gather the corner fields; index matches the corner number
   always_comb begin
      req_cell.lev = {req_level_3, req_level_2, req_level_1, req_level_0};
      req_cell.px  = {req_pos_x_3, req_pos_x_2, req_pos_x_1, req_pos_x_0};
      req_cell.py  = {req_pos_y_3, req_pos_y_2, req_pos_y_1, req_pos_y_0};
   end

   // classify the cell and issue one segment a cycle
   msc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_cell  (req_cell),
      .threshold (threshold_ff),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // decouple issue from the arithmetic pipeline
   msc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   // interpolate both edge points and drive the result strobe
   msc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .threshold        (threshold_ff),
      .qstat            (qstat),
      .pop_data         (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_last_in_cell (rsp_last_in_cell)
   );

endmodule

FILE: rtl/msc_checker.sv
// Port-level checks for the marching squares cell block, bound to the top
`include "marching_squares_cell_segments_defines.svh"

module msc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_in_cell
);

   logic take;
   assign take = start && !busy;

   `MSC_ASSERT_NEXT(a_idle_after_reset, clock, reset, !rsp_valid, "result after reset")
   `MSC_ASSERT_NEXT(a_ready_after_reset, clock, reset, !busy, "busy after reset")
   `MSC_ASSERT_NEXT_RST(a_saddle_pair, clock, reset, rsp_valid && !rsp_last_in_cell, rsp_valid && rsp_last_in_cell, "saddle pair split")
   `MSC_ASSERT_NEXT_RST(a_take_holds_busy, clock, reset, take && busy, 1'b0, "taken while busy")

endmodule

bind marching_squares_cell_segments msc_checker u_msc_checker (.*);

FILE: verif/marching_squares_cell_segments_tb.sv
// Self-checking testbench for the marching squares cell segment extractor
module marching_squares_cell_segments_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msc_pkg::*;

   localparam int PipeLatency = 21;
   localparam q16_type MinQ16 = 32'sh8000_0000;
   localparam q16_type MaxQ16 = 32'sh7fff_ffff;

   typedef struct {
      q16_type sx;
      q16_type sy;
      q16_type ex;
      q16_type ey;
      logic    last;
   } segment_type;

   // Expected segments and the prediction of them from accepted cells
   class segment_scoreboard;
      q16_type       threshold;
      segment_type   pending[$];
      int            errors;

      function new();
         threshold = '0;
         errors = 0;
      endfunction

      // Edge point between corners a and b
      function automatic void edge_point(cell_type c, int a, int b,
                                         output q16_type ox, output q16_type oy);
         longint den, r, prx, pry;
         den = longint'(c.lev[b]) - longint'(c.lev[a]);
         if (den == 0) r = 32768;
         else r = ((longint'(threshold) - longint'(c.lev[a])) * 65536) / den;
         if (r < 0) r = 0;
         if (r > 65536) r = 65536;
         prx = r * (longint'(c.px[b]) - longint'(c.px[a]));
         pry = r * (longint'(c.py[b]) - longint'(c.py[a]));
         // arithmetic shift floors
         ox = q16_type'(longint'(c.px[a]) + (prx >>> 16));
         oy = q16_type'(longint'(c.py[a]) + (pry >>> 16));
      endfunction

      function automatic void add_seg(q16_type ex[4], q16_type ey[4],
                                      edge_code_type s, edge_code_type e, logic last);
         segment_type g;
         g.sx = ex[s]; g.sy = ey[s]; g.ex = ex[e]; g.ey = ey[e]; g.last = last;
         pending.insert(pending.size(), g);
      endfunction

      // Note an accepted cell and queue its segments
      function automatic void note_cell(cell_type c);
         q16_type ex[4], ey[4];
         logic [3:0] mask;
         longint sum;
         logic low_center;
         mask = '0;
         for (int i = 0; i < 4; i++)
            if (c.lev[i] == NoDataLevel) return;
         for (int i = 0; i < 4; i++)
            if (c.lev[i] <= threshold) mask[i] = 1'b1;
         if (mask == 4'd0 || mask == 4'd15) return;
         for (int i = 0; i < 4; i++) edge_point(c, i, (i + 1) % 4, ex[i], ey[i]);
         sum = longint'(c.lev[0]) + c.lev[1] + c.lev[2] + c.lev[3];
         low_center = sum <= 4 * longint'(threshold);
         case (mask) inside
            4'd1, 4'd14: add_seg(ex, ey, EDGE_LEFT, EDGE_TOP, 1'b1);
            4'd2, 4'd13: add_seg(ex, ey, EDGE_TOP, EDGE_RIGHT, 1'b1);
            4'd3, 4'd12: add_seg(ex, ey, EDGE_LEFT, EDGE_RIGHT, 1'b1);
            4'd4, 4'd11: add_seg(ex, ey, EDGE_RIGHT, EDGE_BOTTOM, 1'b1);
            4'd6, 4'd9:  add_seg(ex, ey, EDGE_TOP, EDGE_BOTTOM, 1'b1);
            4'd7, 4'd8:  add_seg(ex, ey, EDGE_LEFT, EDGE_BOTTOM, 1'b1);
            default: begin
               if (low_center == (mask == 4'd5)) begin
                  add_seg(ex, ey, EDGE_TOP, EDGE_RIGHT, 1'b0);
                  add_seg(ex, ey, EDGE_BOTTOM, EDGE_LEFT, 1'b1);
               end else begin
                  add_seg(ex, ey, EDGE_LEFT, EDGE_TOP, 1'b0);
                  add_seg(ex, ey, EDGE_RIGHT, EDGE_BOTTOM, 1'b1);
               end
            end
         endcase
      endfunction

      // Compare one delivered segment with the oldest expectation
      function automatic void check_segment(segment_type got);
         segment_type w;
         if (pending.size() == 0) begin
            $error("unexpected segment %h %h %h %h", got.sx, got.sy, got.ex, got.ey);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.sx !== w.sx) begin
            $error("start_x expected %h got %h", w.sx, got.sx); errors++;
         end
         if (got.sy !== w.sy) begin
            $error("start_y expected %h got %h", w.sy, got.sy); errors++;
         end
         if (got.ex !== w.ex) begin
            $error("end_x expected %h got %h", w.ex, got.ex); errors++;
         end
         if (got.ey !== w.ey) begin
            $error("end_y expected %h got %h", w.ey, got.ey); errors++;
         end
         if (got.last !== w.last) begin
            $error("last_in_cell expected %b got %b", w.last, got.last); errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   cell_type cell_drv = '0;
   logic    rsp_valid;
   q16_type rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic    rsp_last_in_cell;
   logic    csr_wr_en = 1'b0;
   q16_type csr_wr_data = '0;

   segment_scoreboard board = new();
   int idle_pct = 14;

   always #4 clock = ~clock;

   marching_squares_cell_segments dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_level_0(cell_drv.lev[0]), .req_level_1(cell_drv.lev[1]),
      .req_level_2(cell_drv.lev[2]), .req_level_3(cell_drv.lev[3]),
      .req_pos_x_0(cell_drv.px[0]), .req_pos_y_0(cell_drv.py[0]),
      .req_pos_x_1(cell_drv.px[1]), .req_pos_y_1(cell_drv.py[1]),
      .req_pos_x_2(cell_drv.px[2]), .req_pos_y_2(cell_drv.py[2]),
      .req_pos_x_3(cell_drv.px[3]), .req_pos_y_3(cell_drv.py[3]),
      .rsp_valid(rsp_valid), .rsp_start_x(rsp_start_x), .rsp_start_y(rsp_start_y),
      .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y),
      .rsp_last_in_cell(rsp_last_in_cell),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Sample the result strobe at every edge; the receiver never stalls
   always @(posedge clock) begin
      segment_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.sx = rsp_start_x; got.sy = rsp_start_y;
         got.ex = rsp_end_x;   got.ey = rsp_end_y;
         got.last = rsp_last_in_cell;
         board.check_segment(got);
      end
   end

   // Hold the cell on the ports until it is taken, idling in front at random;
   // start is left high; an idle cycle in the next call, or the drain, drops it
   task automatic send_cell(cell_type c);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      cell_drv <= c;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_cell(c);
   endtask

   // Wait for every expected segment plus the pipeline tail before the next write
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PipeLatency + 4) @(posedge clock);
   endtask

   task automatic set_threshold(q16_type t);
      csr_wr_en <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      board.threshold = t;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic q16_type rand_q16();
      case ($urandom_range(5))
         0: return q16_type'($urandom);
         1: return MinQ16;
         2: return MaxQ16;
         default: return q16_type'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
      endcase
   endfunction

   // Levels mostly spread around the threshold so every case mask appears
   function automatic cell_type rand_cell(q16_type t);
      cell_type c;
      int span;
      span = 1 << $urandom_range(20);
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(9) == 0) c.lev[i] = rand_q16();
         else c.lev[i] = q16_type'(longint'(t) + $urandom_range(0, 2 * span) - span);
         if ($urandom_range(99) == 0) c.lev[i] = NoDataLevel;
         c.px[i] = ($urandom_range(7) == 0) ? rand_q16() : q16_type'($urandom_range(0, 1 << 20));
         c.py[i] = ($urandom_range(7) == 0) ? rand_q16() : q16_type'($urandom_range(0, 1 << 20));
      end
      return c;
   endfunction

   function automatic cell_type make_cell(q16_type l0, q16_type l1, q16_type l2,
                                          q16_type l3);
      cell_type c;
      c.lev = {l3, l2, l1, l0};
      c.px = {32'sh0, 32'sh10000, 32'sh10000, 32'sh0};
      c.py = {32'sh10000, 32'sh10000, 32'sh0, 32'sh0};
      return c;
   endfunction

   initial begin
      cell_type c;
      q16_type thr;
      q16_type lo, hi;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every case mask, saddles both ways, no data, flat edges, extremes
      lo = -32'sh10000; hi = 32'sh10000;
      for (int m = 0; m < 16; m++)
         send_cell(make_cell(m[0] ? lo : hi, m[1] ? lo : hi, m[2] ? lo : hi,
                             m[3] ? lo : hi));
      send_cell(make_cell(-32'sh30000, hi, -32'sh30000, hi));
      send_cell(make_cell(lo, 32'sh30000, lo, 32'sh30000));
      send_cell(make_cell(NoDataLevel, hi, lo, hi));
      send_cell(make_cell(32'sh0, 32'sh0, hi, hi));
      c = make_cell(MinQ16 + 1, MaxQ16, MaxQ16, MinQ16 + 1);
      c.px = {MinQ16, MaxQ16, MinQ16, MaxQ16};
      c.py = {MaxQ16, MinQ16, MaxQ16, MinQ16};
      send_cell(c);
      // Pause until every expected segment has come
      drain();

      // Three idling phases; threshold changes between blocks, extremes included
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 14 : (ph == 1) ? 81 : 0;
         for (int blk = 0; blk < 5; blk++) begin
            case (blk)
               0: thr = MinQ16;
               1: thr = MaxQ16;
               2: thr = '0;
               default: thr = q16_type'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
            endcase
            set_threshold(thr);
            for (int n = 0; n < 130; n++) send_cell(rand_cell(thr));
            drain();
         end
      end
      set_threshold('0);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("marching_squares_cell_segments regression: pass");
      else
         $display("marching_squares_cell_segments regression: fail");
      $finish;
   end

   initial begin
      #2ms;
      $display("marching_squares_cell_segments regression: fail");
      $finish;
   end
endmodule
